// File: rtl/assert_macros.svh
// Assertion macros for the RTL that checks itself.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/hem_pkg.sv
// Shared types, constants and helpers for the heavy edge matcher.
// No dependencies; used by every module of the block.
package hem_pkg;

    localparam int NUM_VERTICES = 4096;
    localparam int ADDR_BITS    = $clog2(NUM_VERTICES);
    localparam int VTX_W        = 12;
    localparam int WEIGHT_BITS  = 16;
    localparam int LIMIT_W      = 17;
    localparam int STATUS_W     = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

    // item kinds
    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_MATCHED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd2;

    localparam logic [VTX_W-1:0] NO_PARTNER = '0;

    typedef logic [VTX_W-1:0]       vtx_t;
    typedef logic [WEIGHT_BITS-1:0] wgt_t;
    typedef logic [ADDR_BITS-1:0]   addr_t;

    typedef struct packed {
        logic rd_en;
        vtx_t src;
        vtx_t nbr;
    } rd_req_t;

    typedef struct packed {
        logic wr_en;
        vtx_t src;
        vtx_t nbr;
    } wr_req_t;

    typedef struct packed {
        logic busy;
        logic src_matched;
        logic nbr_matched;
    } store_stat_t;

    function automatic addr_t to_addr(vtx_t v);
        return ADDR_BITS'(v);
    endfunction

    function automatic logic in_range(vtx_t v);
        return 33'(v) < 33'(NUM_VERTICES);
    endfunction

endpackage

// File: rtl/hem_match_store.sv
// Matched-vertex bit store: two 1-bit RAMs (source side, partner side),
// read at two addresses per item, clearing sweep, write forwarding. Uses hem_pkg.
module hem_match_store (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear_start,
    input  hem_pkg::rd_req_t     rd,
    input  hem_pkg::wr_req_t     wr,
    output hem_pkg::store_stat_t stat
);
    import hem_pkg::*;

    logic mem_src [NUM_VERTICES];
    logic mem_nbr [NUM_VERTICES];

    logic  sweep_reg, sweep_next;
    addr_t sweep_cnt_reg, sweep_cnt_next;

    logic fwd_valid_reg, fwd_valid_next;
    vtx_t fwd_src_reg, fwd_nbr_reg;

    vtx_t ra_reg, rb_reg;
    logic ra_ok_reg, rb_ok_reg;
    logic rs_a_reg, rn_a_reg, rs_b_reg, rn_b_reg;

    // sweep control
    always_comb begin
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (clear_start) begin
            sweep_next     = 1'b1;
            sweep_cnt_next = '0;
        end else if (sweep_reg) begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
            if (sweep_cnt_reg == ADDR_BITS'(NUM_VERTICES - 1)) begin
                sweep_next = 1'b0;
            end
        end
    end

    always_comb begin
        fwd_valid_next = fwd_valid_reg;
        if (sweep_reg || clear_start) begin
            fwd_valid_next = 1'b0;
        end else if (wr.wr_en) begin
            fwd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    // RAM write port (one per array) and two read ports, read-first
    always_ff @(posedge aclk) begin
        if (sweep_reg) begin
            mem_src[sweep_cnt_reg] <= 1'b0;
            mem_nbr[sweep_cnt_reg] <= 1'b0;
        end else if (wr.wr_en) begin
            if (in_range(wr.src)) begin
                mem_src[to_addr(wr.src)] <= 1'b1;
            end
            if (in_range(wr.nbr)) begin
                mem_nbr[to_addr(wr.nbr)] <= 1'b1;
            end
        end
        if (rd.rd_en) begin
            rs_a_reg <= mem_src[to_addr(rd.src)];
            rn_a_reg <= mem_nbr[to_addr(rd.src)];
            rs_b_reg <= mem_src[to_addr(rd.nbr)];
            rn_b_reg <= mem_nbr[to_addr(rd.nbr)];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.rd_en) begin
            ra_reg    <= rd.src;
            rb_reg    <= rd.nbr;
            ra_ok_reg <= in_range(rd.src);
            rb_ok_reg <= in_range(rd.nbr);
        end
        if (wr.wr_en) begin
            fwd_src_reg <= wr.src;
            fwd_nbr_reg <= wr.nbr;
        end
    end

    // the match written on the read edge is not yet in the RAM data
    always_comb begin
        stat.busy        = sweep_reg;
        stat.src_matched = !ra_ok_reg || rs_a_reg || rn_a_reg ||
                           (fwd_valid_reg && (ra_reg == fwd_src_reg || ra_reg == fwd_nbr_reg));
        stat.nbr_matched = !rb_ok_reg || rs_b_reg || rn_b_reg ||
                           (fwd_valid_reg && (rb_reg == fwd_src_reg || rb_reg == fwd_nbr_reg));
    end

endmodule

// File: rtl/hem_select.sv
// Decision stage: per-vertex best-edge tracking, match write request and
// result register. Uses hem_pkg; driven by the store status of hem_match_store.
module hem_select (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [hem_pkg::LIMIT_W-1:0]   limit,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_kind,
    input  hem_pkg::vtx_t                 in_vertex,
    input  hem_pkg::wgt_t                 in_vertex_weight,
    input  logic                          in_has_edge,
    input  hem_pkg::vtx_t                 in_neighbor,
    input  hem_pkg::wgt_t                 in_neighbor_weight,
    input  hem_pkg::wgt_t                 in_edge_weight,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hem_pkg::vtx_t                 out_vertex,
    output hem_pkg::vtx_t                 out_partner,
    output logic [hem_pkg::STATUS_W-1:0]  out_status,
    input  hem_pkg::store_stat_t          stat,
    output hem_pkg::rd_req_t              rd,
    output hem_pkg::wr_req_t              wr,
    output logic                          clear_start
);
    import hem_pkg::*;

    logic s1_valid_reg, s1_valid_next;
    logic s1_kind_reg, s1_has_edge_reg, s1_last_reg;
    vtx_t s1_vertex_reg, s1_nbr_reg;
    wgt_t s1_vw_reg, s1_nw_reg, s1_ew_reg;

    logic mid_reg, mid_next;
    logic have_best_reg, have_best_next;
    logic src_am_reg, src_am_next;
    wgt_t best_pri_reg, best_pri_next;
    vtx_t best_par_reg, best_par_next;

    logic                out_valid_reg, out_valid_next;
    vtx_t                out_vertex_reg, out_partner_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                out_free, s1_adv, accept, emit;
    logic                src_am, hb, elig, take, new_hb;
    wgt_t                new_pri;
    vtx_t                new_par;
    logic [LIMIT_W-1:0]  wsum;
    vtx_t                res_partner;
    logic [STATUS_W-1:0] res_status;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && (s1_kind_reg || !s1_last_reg || out_free);
    assign in_ready = !stat.busy && !(s1_valid_reg && s1_kind_reg) &&
                      (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;

    assign rd.rd_en = accept;
    assign rd.src   = in_vertex;
    assign rd.nbr   = in_neighbor;

    assign clear_start = s1_valid_reg && s1_kind_reg;

    // candidate evaluation
    always_comb begin
        src_am  = mid_reg ? src_am_reg : stat.src_matched;
        hb      = mid_reg && have_best_reg;
        wsum    = LIMIT_W'(s1_vw_reg) + LIMIT_W'(s1_nw_reg);
        elig    = s1_has_edge_reg && !src_am && !stat.nbr_matched && (wsum <= limit);
        take    = elig && (!hb || (best_pri_reg < s1_ew_reg));
        new_hb  = hb || take;
        new_pri = take ? s1_ew_reg  : best_pri_reg;
        new_par = take ? s1_nbr_reg : best_par_reg;
    end

    always_comb begin
        priority if (src_am) begin
            res_status  = ST_ALREADY;
            res_partner = NO_PARTNER;
        end else if (new_hb) begin
            res_status  = ST_MATCHED;
            res_partner = new_par;
        end else begin
            res_status  = ST_NONE;
            res_partner = NO_PARTNER;
        end
    end

    assign emit      = s1_adv && !s1_kind_reg && s1_last_reg;
    assign wr.wr_en  = emit && (res_status == ST_MATCHED);
    assign wr.src    = s1_vertex_reg;
    assign wr.nbr    = new_par;

    always_comb begin
        mid_next       = mid_reg;
        have_best_next = have_best_reg;
        src_am_next    = src_am_reg;
        best_pri_next  = best_pri_reg;
        best_par_next  = best_par_reg;
        if (s1_adv) begin
            if (s1_kind_reg) begin
                mid_next       = 1'b0;
                have_best_next = 1'b0;
            end else begin
                src_am_next    = src_am;
                best_pri_next  = new_pri;
                best_par_next  = new_par;
                mid_next       = !s1_last_reg;
                have_best_next = !s1_last_reg && new_hb;
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mid_reg       <= 1'b0;
            have_best_reg <= 1'b0;
            src_am_reg    <= 1'b0;
            best_pri_reg  <= '0;
            best_par_reg  <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            mid_reg       <= mid_next;
            have_best_reg <= have_best_next;
            src_am_reg    <= src_am_next;
            best_pri_reg  <= best_pri_next;
            best_par_reg  <= best_par_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_kind_reg     <= in_kind;
            s1_vertex_reg   <= in_vertex;
            s1_vw_reg       <= in_vertex_weight;
            s1_has_edge_reg <= in_has_edge;
            s1_nbr_reg      <= in_neighbor;
            s1_nw_reg       <= in_neighbor_weight;
            s1_ew_reg       <= in_edge_weight;
            s1_last_reg     <= in_last;
        end
        if (emit) begin
            out_vertex_reg  <= s1_vertex_reg;
            out_partner_reg <= res_partner;
            out_status_reg  <= res_status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_vertex  = out_vertex_reg;
    assign out_partner = out_partner_reg;
    assign out_status  = out_status_reg;

endmodule

// File: rtl/heavy_edge_matcher.sv
// Greedy heavy-edge matcher. The transfer of a vertex's last item reads the RAM and registers
// the item; the decision then enters the output register once that register is free.
// Throughput: one item per cycle, set by the single decide stage and one RAM write per array,
// while no sweep runs, no clear is decoded and each last item finds the output register free.
// Reset (aresetn low, synchronous) starts a sweep of the matched store, and a clear item
// holds s_tready low while decoded, then through the sweep. Config writes are taken at any time.
module heavy_edge_matcher (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: max_coarse_weight
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] vertex, [27:12] vertex_weight, [28] has_edge, [40:29] neighbor,
    // [56:41] neighbor_weight, [72:57] edge_weight, [79:73] zero
    input  logic [79:0] s_tdata,
    input  logic        s_tuser,   // [0] kind
    input  logic        s_tlast,   // last_edge
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [11:0] vertex_res, [23:12] partner
    output logic [1:0]  m_tuser    // [1:0] status
);
    import hem_pkg::*;

    `include "assert_macros.svh"

    logic [LIMIT_W-1:0] limit_reg, limit_next;

    rd_req_t     rd;
    wr_req_t     wr;
    store_stat_t stat;
    logic        clear_start;

    vtx_t                res_vertex, res_partner;
    logic [STATUS_W-1:0] res_status;

    // limit register, to be written only while the block is idle (not enforced by the block)
    assign limit_next = cfg_we ? cfg_wdata : limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    hem_match_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear_start (clear_start),
        .rd          (rd),
        .wr          (wr),
        .stat        (stat)
    );

    hem_select u_select (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .limit              (limit_reg),
        .in_valid           (s_tvalid),
        .in_ready           (s_tready),
        .in_kind            (s_tuser),
        .in_vertex          (s_tdata[11:0]),
        .in_vertex_weight   (s_tdata[27:12]),
        .in_has_edge        (s_tdata[28]),
        .in_neighbor        (s_tdata[40:29]),
        .in_neighbor_weight (s_tdata[56:41]),
        .in_edge_weight     (s_tdata[72:57]),
        .in_last            (s_tlast),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_vertex         (res_vertex),
        .out_partner        (res_partner),
        .out_status         (res_status),
        .stat               (stat),
        .rd                 (rd),
        .wr                 (wr),
        .clear_start        (clear_start)
    );

    assign m_tdata = {res_partner, res_vertex};
    assign m_tuser = res_status;

    // no item may enter while the store is being swept
    `ASSERT_NEVER(a_no_accept_in_sweep, aclk, aresetn, stat.busy && s_tready, "item during sweep")
    // an accepted clear item is registered and raises clear_start, which then starts the sweep
    `ASSERT_CLK(a_clear_sweeps, aclk, aresetn,
        (s_tvalid && s_tready && s_tuser == KIND_CLEAR) |-> ##2 stat.busy, "clear did not sweep")
    // only a match carries a partner
    `ASSERT_CLK(a_partner_only_on_match, aclk, aresetn,
        (m_tvalid && m_tuser != ST_MATCHED) |-> (m_tdata[23:12] == NO_PARTNER),
        "partner without match")

endmodule

// File: bench/heavy_edge_matcher_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for heavy_edge_matcher: directed corner cases, then random edge
// groups under several idle/stall mixes. Depends on hem_pkg and the matcher RTL.
module heavy_edge_matcher_tb;
    import hem_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;  // clear sweeps dominate the run time
    localparam int SETTLE_CYCLES = 8;          // slack after the last decision
    localparam int VTX_WINDOW    = 64;         // dense vertex range so matches collide

    // one input transfer, fields as the block sees them
    typedef struct packed {
        logic kind;
        vtx_t vertex;
        wgt_t vertex_weight;
        logic has_edge;
        vtx_t neighbor;
        wgt_t neighbor_weight;
        wgt_t edge_weight;
        logic last_edge;
    } edge_item_t;

    // one decision on the result channel
    typedef struct packed {
        vtx_t                vertex;
        vtx_t                partner;
        logic [STATUS_W-1:0] status;
    } match_result_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [79:0]        s_tdata;
    logic               s_tuser;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;
    logic [1:0]         m_tuser;

    // matching model state
    bit                 matched_map [NUM_VERTICES];
    vtx_t               best_nbr;
    wgt_t               best_edge_weight;
    bit                 have_best;
    bit                 src_was_matched;
    bit                 in_group;
    logic [LIMIT_W-1:0] weight_limit;
    match_result_t      expected_matches[$];

    // traffic shaping, percent of cycles idle/stalled
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_req  = 0;   // set by a test, taken over by the receiver process
    int hold_left = 0;

    int error_count = 0;
    int cycle_count = 0;

    match_result_t got_res;
    match_result_t want_res;

    heavy_edge_matcher DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [11:0] vertex, [27:12] vertex_weight, [28] has_edge,
                                // [40:29] neighbor, [56:41] neighbor_weight,
                                // [72:57] edge_weight, [79:73] zero
        .s_tuser   (s_tuser),   // [0] kind
        .s_tlast   (s_tlast),   // last_edge
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [11:0] vertex_res, [23:12] partner
        .m_tuser   (m_tuser)    // [1:0] status
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("heavy_edge_matcher_tb NOT OK");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here when a test asks.
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Result check: every accepted transfer pops the oldest expected decision.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = '{vertex: m_tdata[11:0], partner: m_tdata[23:12], status: m_tuser};
            if (expected_matches.size() == 0) begin
                $error("unexpected result: vertex_res %0d partner %0d status %0d",
                       got_res.vertex, got_res.partner, got_res.status);
                error_count++;
            end else begin
                want_res = expected_matches.pop_front();
                if (got_res.vertex !== want_res.vertex) begin
                    $error("vertex_res: expected %0d, got %0d", want_res.vertex,
                           got_res.vertex);
                    error_count++;
                end
                if (got_res.partner !== want_res.partner) begin
                    $error("partner: expected %0d, got %0d", want_res.partner,
                           got_res.partner);
                    error_count++;
                end
                if (got_res.status !== want_res.status) begin
                    $error("status: expected %0d, got %0d", want_res.status,
                           got_res.status);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Matching model
    // ---------------------------------------------------------------------------

    // out-of-range indexes count as matched
    function automatic bit is_matched(vtx_t v);
        if (int'(v) >= NUM_VERTICES) return 1'b1;
        return matched_map[int'(v)];
    endfunction

    function automatic void mark_matched(vtx_t v);
        if (int'(v) < NUM_VERTICES) matched_map[int'(v)] = 1'b1;
    endfunction

    function automatic void clear_matched();
        foreach (matched_map[i]) matched_map[i] = 1'b0;
        in_group  = 1'b0;
        have_best = 1'b0;
    endfunction

    // Advance the model by one accepted transfer; queue the decision it causes.
    function automatic void predict_match(edge_item_t it);
        match_result_t d;
        if (it.kind == KIND_CLEAR) begin
            clear_matched();
            return;
        end
        // first transfer of a group latches the source's matched bit
        if (!in_group) begin
            src_was_matched = is_matched(it.vertex);
            have_best       = 1'b0;
        end
        // weight sum compared at full width, ties keep the first edge
        if (it.has_edge && !src_was_matched && !is_matched(it.neighbor) &&
            int'(it.vertex_weight) + int'(it.neighbor_weight) <= int'(weight_limit)) begin
            if (!have_best || best_edge_weight < it.edge_weight) begin
                best_edge_weight = it.edge_weight;
                best_nbr         = it.neighbor;
                have_best        = 1'b1;
            end
        end
        if (!it.last_edge) begin
            in_group = 1'b1;
            return;
        end
        // decision uses the vertex index of the last transfer
        d.vertex = it.vertex;
        if (src_was_matched) begin
            d.partner = NO_PARTNER;
            d.status  = ST_ALREADY;
        end else if (have_best) begin
            mark_matched(it.vertex);
            mark_matched(best_nbr);
            d.partner = best_nbr;
            d.status  = ST_MATCHED;
        end else begin
            d.partner = NO_PARTNER;
            d.status  = ST_NONE;
        end
        in_group  = 1'b0;
        have_best = 1'b0;
        expected_matches.push_back(d);
    endfunction

    // ---------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------

    function automatic edge_item_t make_item(logic kind, int v, int vw, logic has_edge,
                                             int nbr, int nw, int ew, logic last_edge);
        edge_item_t it;
        it.kind            = kind;
        it.vertex          = vtx_t'(v);
        it.vertex_weight   = wgt_t'(vw);
        it.has_edge        = has_edge;
        it.neighbor        = vtx_t'(nbr);
        it.neighbor_weight = wgt_t'(nw);
        it.edge_weight     = wgt_t'(ew);
        it.last_edge       = last_edge;
        return it;
    endfunction

    // mostly inside the dense window, sometimes anywhere
    function automatic vtx_t pick_vertex(int base);
        if ($urandom_range(0, 9) == 0) return vtx_t'($urandom);
        return vtx_t'(base + $urandom_range(0, VTX_WINDOW - 1));
    endfunction

    // small values, full range, extremes, and values near half the limit
    function automatic wgt_t rand_weight();
        case ($urandom_range(0, 3))
            0: return wgt_t'($urandom_range(0, 15));
            1: return wgt_t'($urandom);
            2: return $urandom_range(0, 1) ? {WEIGHT_BITS{1'b1}} : '0;
            default: return wgt_t'((weight_limit >> 1) + $urandom_range(0, 2) - 1);
        endcase
    endfunction

    function automatic edge_item_t random_item(int base);
        edge_item_t it;
        it.kind            = KIND_EDGE;
        it.vertex          = pick_vertex(base);
        it.vertex_weight   = rand_weight();
        it.has_edge        = 1'b1;
        it.neighbor        = pick_vertex(base);
        it.neighbor_weight = rand_weight();
        // narrow edge weights give plenty of ties
        it.edge_weight     = $urandom_range(0, 1) ? wgt_t'($urandom_range(0, 3))
                                                  : wgt_t'($urandom);
        it.last_edge       = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Drive one item from the falling edge, hold it until the transfer.
    task automatic send_item(edge_item_t it);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, it.edge_weight, it.neighbor_weight, it.neighbor, it.has_edge,
                     it.vertex_weight, it.vertex};
        s_tuser  <= it.kind;
        s_tlast  <= it.last_edge;
        do @(posedge aclk); while (!s_tready);
        predict_match(it);
    endtask

    // Drop valid, wait for every decision, then let the pipe settle.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_limit(logic [LIMIT_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        weight_limit = value;
    endtask

    // One source vertex: a well-formed group most of the time, with noise mixed in
    // (clear items, vertex index switching mid group, a missing last flag).
    task automatic send_random_group(input int base, output int n_sent);
        edge_item_t head;
        edge_item_t e;
        int         n_edges;
        n_sent = 0;
        head   = random_item(base);
        if ($urandom_range(0, 99) < 3) begin
            head.kind = KIND_CLEAR;
            send_item(head);
            n_sent = 1;
            return;
        end
        n_edges = $urandom_range(0, 5);
        if (n_edges == 0) begin
            head.has_edge  = 1'b0;
            head.last_edge = 1'b1;
            send_item(head);
            n_sent = 1;
            return;
        end
        for (int i = 0; i < n_edges; i++) begin
            e = random_item(base);
            if ($urandom_range(0, 19) != 0) begin
                e.vertex        = head.vertex;
                e.vertex_weight = head.vertex_weight;
            end
            e.has_edge  = ($urandom_range(0, 9) != 0);
            e.last_edge = (i == n_edges - 1) && ($urandom_range(0, 29) != 0);
            if ($urandom_range(0, 49) == 0) begin
                // clear in the middle abandons the group
                head.kind = KIND_CLEAR;
                send_item(head);
                n_sent++;
            end
            send_item(e);
            n_sent++;
        end
    endtask

    // ---------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------

    task automatic test_special_cases();
        idle_pct  = 0;
        stall_pct = 0;
        // edgeless vertex, edge fields ignored
        send_item(make_item(KIND_EDGE, 0, 1, 1'b0, 4095, 65535, 65535, 1'b1));
        // heaviest wins, tie between 3 and 4 keeps 3
        send_item(make_item(KIND_EDGE, 1, 1, 1'b1, 2, 1, 5, 1'b0));
        send_item(make_item(KIND_EDGE, 1, 1, 1'b1, 3, 1, 9, 1'b0));
        send_item(make_item(KIND_EDGE, 1, 1, 1'b1, 4, 1, 9, 1'b1));
        // source already matched
        send_item(make_item(KIND_EDGE, 3, 1, 1'b1, 5, 1, 7, 1'b1));
        // only neighbor already matched
        send_item(make_item(KIND_EDGE, 5, 1, 1'b1, 1, 1, 7, 1'b1));
        // self loop at top index, largest weights, sum just under the reset limit
        send_item(make_item(KIND_EDGE, 4095, 65535, 1'b1, 4095, 65535, 65535, 1'b1));
        // vertex index changes within the group
        send_item(make_item(KIND_EDGE, 11, 1, 1'b1, 12, 1, 1, 1'b0));
        send_item(make_item(KIND_EDGE, 13, 1, 1'b1, 14, 1, 2, 1'b1));
        // edgeless item in the middle of a group
        send_item(make_item(KIND_EDGE, 30, 1, 1'b0, 31, 1, 65535, 1'b0));
        send_item(make_item(KIND_EDGE, 30, 1, 1'b1, 32, 1, 0, 1'b1));
        // clear abandons the open group and frees vertex 3
        send_item(make_item(KIND_EDGE, 20, 1, 1'b1, 21, 1, 3, 1'b0));
        send_item(make_item(KIND_CLEAR, 4095, 65535, 1'b1, 4095, 65535, 65535, 1'b1));
        send_item(make_item(KIND_EDGE, 3, 1, 1'b1, 22, 1, 1, 1'b1));
    endtask

    task automatic test_weight_limit();
        set_limit('0);
        send_item(make_item(KIND_EDGE, 40, 0, 1'b1, 41, 0, 0, 1'b1));   // sum 0 fits
        send_item(make_item(KIND_EDGE, 42, 0, 1'b1, 43, 1, 0, 1'b1));   // sum 1 too heavy
        set_limit(17'd100);
        send_item(make_item(KIND_EDGE, 50, 60, 1'b1, 51, 41, 65535, 1'b0));  // over by one
        send_item(make_item(KIND_EDGE, 50, 60, 1'b1, 52, 40, 0, 1'b1));      // exactly at
        set_limit(LIMIT_RESET);
    endtask

    task automatic test_random(int idle, int stall, logic [LIMIT_W-1:0] limit, int n_items);
        int base;
        int sent;
        int n;
        set_limit(limit);
        idle_pct  = idle;
        stall_pct = stall;
        base = $urandom_range(0, NUM_VERTICES - VTX_WINDOW);
        sent = 0;
        while (sent < n_items) begin
            send_random_group(base, n);
            sent += n;
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the input backs up;
    // afterwards the sender waits for every outstanding decision.
    task automatic test_backpressure();
        int base;
        int sent;
        int n;
        wait_idle();
        idle_pct  = 0;
        stall_pct = 0;
        @(posedge aclk);
        hold_req = 400;
        base = $urandom_range(0, NUM_VERTICES - VTX_WINDOW);
        sent = 0;
        while (sent < 80) begin
            send_random_group(base, n);
            sent += n;
        end
        wait_idle();
    endtask

    // ---------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_EDGE;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        clear_matched();
        best_nbr         = '0;
        best_edge_weight = '0;
        src_was_matched  = 1'b0;
        weight_limit     = LIMIT_RESET;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // store sweep after reset holds s_tready low; send_item waits it out
        test_special_cases();
        test_weight_limit();
        test_random(0, 0, LIMIT_RESET, 430);
        test_random(61, 0, 17'($urandom_range(0, 131071)), 430);
        test_random(0, 61, 17'd65535, 430);
        test_random(37, 37, 17'd40, 430);
        test_backpressure();

        wait_idle();
        if (expected_matches.size() != 0) begin
            $error("%0d decisions never arrived", expected_matches.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("heavy_edge_matcher_tb OK");
        end else begin
            $display("heavy_edge_matcher_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/hem_pkg.sv
rtl/hem_match_store.sv
rtl/hem_select.sv
rtl/heavy_edge_matcher.sv
bench/heavy_edge_matcher_tb.sv
